// ===== rtl/sgs_pkg.sv =====
package sgs_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int RANGE_BITS_DEF = 16;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ANGLE_START = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ANGLE_STEP  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INNER_MARG  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAIN        = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FWD_SPEED   = 3'd6;

   // polynomial coefficients, Q15
   localparam logic [16:0] PI_Q15     = 17'd102944;
   localparam logic [15:0] C2PI5_Q15  = 16'd42047;
   localparam logic [12:0] PI3_Q15    = 13'd4640;
   localparam int          CORR_MAX   = 32767;

   // word moved from front to back
   typedef struct packed {
      logic signed [16:0] x_mm;   // lateral, clamped
      logic signed [16:0] y_mm;
      logic               valid;
      logic               last;
   } point_type;

endpackage

// ===== rtl/scan_gap_steering_core.sv =====
// Scan gap steering core. Range words are pushed one at a time; each passes
// through the sequenced sine/cosine and scaling front (one shared multiply
// step per cycle), so full stays high after a push until the front is idle.
// The back stage applies a word after the front's final step and queues one result per
// scan on the last sample. Registers may be written only while idle.
module scan_gap_steering_core #(
   parameter int ANGLE_BITS = sgs_pkg::ANGLE_BITS_DEF,
   parameter int RANGE_BITS = sgs_pkg::RANGE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [15:0]                         req_range_mm,
   input  logic                                req_range_valid,
   input  logic                                req_last_sample,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [16:0]                  rsp_turn_rate,
   output logic [11:0]                         rsp_linear_speed,
   input  logic                                csr_write,
   input  logic [sgs_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [sgs_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import sgs_pkg::*;

   logic signed [15:0] start_ff;
   logic [11:0] step_ff, gain_ff, speed_ff;
   logic [15:0] hw_ff, im_ff, th_ff;
   logic busy, room, go, fgo;
   point_type pt;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= -16'sd8192; step_ff <= 12'd182; hw_ff <= 16'd400;
         im_ff <= 16'd100; th_ff <= 16'd1000; gain_ff <= 12'd435; speed_ff <= 12'd400;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ANGLE_START: start_ff <= signed'(csr_data);
            CSR_ANGLE_STEP:  step_ff <= csr_data[11:0];
            CSR_HALF_WIDTH:  hw_ff <= csr_data;
            CSR_INNER_MARG:  im_ff <= csr_data;
            CSR_THRESHOLD:   th_ff <= csr_data;
            CSR_GAIN:        gain_ff <= csr_data[11:0];
            CSR_FWD_SPEED:   speed_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   assign req_full = busy || !room;
   assign go = req_push && !req_full;

   sgs_front #(.ANGLE_BITS(ANGLE_BITS), .RANGE_BITS(RANGE_BITS)) u_front (
      .clock, .reset, .in_go(go), .in_range(RANGE_BITS'(req_range_mm)),
      .in_valid(req_range_valid), .in_last(req_last_sample),
      .angle_start(start_ff), .angle_step(step_ff),
      .out_go(fgo), .out_point(pt), .busy);

   sgs_back u_back (
      .clock, .reset, .in_go(fgo), .in_point(pt), .half_width(hw_ff),
      .inner_margin(im_ff), .threshold(th_ff), .gain(gain_ff), .fwd_speed(speed_ff),
      .pop(rsp_pop), .empty(rsp_empty), .room,
      .turn_rate(rsp_turn_rate), .linear_speed(rsp_linear_speed));
endmodule

// ===== rtl/sgs_front.sv =====
// Front: beam angle tracking, quarter-wave sine/cosine, point coordinates.
module sgs_front #(
   parameter int ANGLE_BITS = sgs_pkg::ANGLE_BITS_DEF,
   parameter int RANGE_BITS = sgs_pkg::RANGE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_go,
   input  logic [RANGE_BITS-1:0] in_range,
   input  logic                  in_valid,
   input  logic                  in_last,
   input  logic signed [15:0]    angle_start,
   input  logic [11:0]           angle_step,
   output logic                  out_go,
   output sgs_pkg::point_type    out_point,
   output logic                  busy
);
   import sgs_pkg::*;

   localparam int QB = ANGLE_BITS - 2;

   typedef enum logic [2:0] {
      S_IDLE, S_X2, S_IN, S_R, S_Y, S_XY
   } state_type;

   state_type state_ff, state_in;
   logic [ANGLE_BITS-1:0] beam_ff, beam_in;
   logic in_scan_ff, in_scan_in;
   logic [RANGE_BITS-1:0] range_ff, range_in;
   logic valid_ff, valid_in, last_ff, last_in;
   // sine and cosine lanes share the sequencer
   logic [16:0] xs_ff [2], xs_in [2];
   logic [16:0] x2_ff [2], x2_in [2];
   logic [16:0] acc_ff [2], acc_in [2];
   logic        neg_ff [2], neg_in [2];
   logic signed [16:0] trig_ff [2], trig_in [2];
   logic signed [16:0] co_ff [2], co_in [2];
   logic go_ff, go_in;

   logic [ANGLE_BITS-1:0] ang;
   logic [ANGLE_BITS-1:0] angs [2];
   logic [33:0] sq [2];
   logic [29:0] p1 [2];
   logic [33:0] p2 [2];
   logic [33:0] p3 [2];
   logic [15:0] inner [2];
   logic signed [RANGE_BITS+17:0] prod [2];
   logic signed [RANGE_BITS+17:0] pabs [2];
   logic [RANGE_BITS+17:0] rnd [2];

   always_comb begin
      ang = in_scan_ff ? beam_ff : ANGLE_BITS'(unsigned'(32'(angle_start)));
      angs[0] = ang;
      angs[1] = ang + (ANGLE_BITS'(1) << QB);
   end

   always_comb begin
      state_in = state_ff;  beam_in = beam_ff;  in_scan_in = in_scan_ff;
      range_in = range_ff;  valid_in = valid_ff; last_in = last_ff;
      go_in = 1'b0;
      for (int i = 0; i < 2; i++) begin
         xs_in[i] = xs_ff[i]; x2_in[i] = x2_ff[i]; acc_in[i] = acc_ff[i];
         neg_in[i] = neg_ff[i]; trig_in[i] = trig_ff[i]; co_in[i] = co_ff[i];
         sq[i] = 34'(xs_ff[i]) * 34'(xs_ff[i]);
         p1[i] = 30'(x2_ff[i]) * 30'(PI3_Q15);
         inner[i] = C2PI5_Q15 - 16'(p1[i] >> 15);
         p2[i] = 34'(x2_ff[i]) * 34'(acc_ff[i]);
         p3[i] = 34'(xs_ff[i]) * 34'(acc_ff[i]);
         prod[i] = $signed({{(RANGE_BITS+1){trig_ff[i][16]}}, trig_ff[i]})
                   * $signed({18'd0, range_ff});
         pabs[i] = prod[i][RANGE_BITS+17] ? -prod[i] : prod[i];
         rnd[i] = (unsigned'(pabs[i]) + (RANGE_BITS+18)'(16384)) >> 15;
      end
      case (state_ff)
         S_IDLE: begin
            if (in_go) begin
               range_in = in_range; valid_in = in_valid; last_in = in_last;
               for (int i = 0; i < 2; i++) begin
                  xs_in[i] = 17'((64'(angs[i][QB-1:0]) << 15) >> QB);
                  if (angs[i][QB]) xs_in[i] = 17'd32768 - xs_in[i];
                  neg_in[i] = angs[i][QB+1];
               end
               if (in_last) begin
                  in_scan_in = 1'b0; beam_in = '0;
               end else begin
                  in_scan_in = 1'b1;
                  beam_in = ang + ANGLE_BITS'(angle_step);
               end
               state_in = S_X2;
            end
         end
         S_X2: begin
            for (int i = 0; i < 2; i++) x2_in[i] = 17'(sq[i] >> 15);
            state_in = S_IN;
         end
         S_IN: begin
            for (int i = 0; i < 2; i++) acc_in[i] = 17'(inner[i]);
            state_in = S_R;
         end
         S_R: begin
            for (int i = 0; i < 2; i++) acc_in[i] = PI_Q15 - 17'(p2[i] >> 15);
            state_in = S_Y;
         end
         S_Y: begin
            for (int i = 0; i < 2; i++) begin
               trig_in[i] = (p3[i] >> 16) > 34'd32767 ? 17'sd32767
                            : signed'(17'(p3[i] >> 16));
               if (neg_ff[i]) trig_in[i] = -trig_in[i];
            end
            state_in = S_XY;
         end
         S_XY: begin
            for (int i = 0; i < 2; i++) begin
               // clamp to 17 bits; band/threshold compare fits in this range
               if (rnd[i] > (RANGE_BITS+18)'(65535)) co_in[i] = 17'sd65535;
               else co_in[i] = signed'(17'(rnd[i]));
               if (prod[i][RANGE_BITS+17]) co_in[i] = -co_in[i];
            end
            go_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; beam_ff <= '0; in_scan_ff <= 1'b0; go_ff <= 1'b0;
      end else begin
         state_ff <= state_in; beam_ff <= beam_in; in_scan_ff <= in_scan_in;
         go_ff <= go_in;
      end
      range_ff <= range_in; valid_ff <= valid_in; last_ff <= last_in;
      xs_ff <= xs_in; x2_ff <= x2_in; acc_ff <= acc_in; neg_ff <= neg_in;
      trig_ff <= trig_in; co_ff <= co_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign out_go = go_ff;
   assign out_point = '{x_mm: co_ff[0], y_mm: co_ff[1], valid: valid_ff, last: last_ff};

`ifndef NO_ASSERTIONS
   a_go_one: assert property (@(posedge clock) disable iff (reset)
      go_ff |=> !go_ff) else $error("front word issued twice");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      in_go |-> state_ff == S_IDLE) else $error("front took word while busy");
   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_XY |-> (trig_ff[0] <= 17'sd32767 && trig_ff[0] >= -17'sd32767))
      else $error("sine out of range");
`endif
endmodule

// ===== rtl/sgs_back.sv =====
// Back: band tests, correction, extreme tracking, result queue.
module sgs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_go,
   input  sgs_pkg::point_type   in_point,
   input  logic [15:0]          half_width,
   input  logic [15:0]          inner_margin,
   input  logic [15:0]          threshold,
   input  logic [11:0]          gain,
   input  logic [11:0]          fwd_speed,
   input  logic                 pop,
   output logic                 empty,
   output logic                 room,
   output logic signed [16:0]   turn_rate,
   output logic [11:0]          linear_speed
);
   import sgs_pkg::*;

   logic signed [16:0] left_ff, left_in, right_ff, right_in;
   logic signed [16:0] fl, fr;
   logic signed [18:0] m;
   logic [30:0] mp;
   logic [22:0] mag_raw;
   logic signed [16:0] mag;
   logic in_left, in_right, near;
   logic [16:0] q_turn [QUEUE_DEPTH];
   logic [11:0] q_spd [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wp_ff, rp_ff;
   logic [QUEUE_PTR_BITS:0] cnt_ff;
   logic push;

   // correction magnitude and band membership
   always_comb begin
      near = in_point.y_mm < signed'({1'b0, threshold});
      m = 19'(signed'({1'b0, threshold})) - 19'(in_point.y_mm);
      mp = 31'(unsigned'(m[17:0])) * 31'(gain) + 31'd128;
      mag_raw = 23'(mp >> 8);
      mag = mag_raw > 23'(CORR_MAX) ? 17'(CORR_MAX) : signed'(17'(mag_raw));
      in_left = in_point.x_mm > -signed'({1'b0, half_width})
             && in_point.x_mm < -signed'({1'b0, inner_margin});
      in_right = in_point.x_mm < signed'({1'b0, half_width})
              && in_point.x_mm > signed'({1'b0, inner_margin});
   end

   // extremes with this point folded in; the last point counts in the sum
   always_comb begin
      fl = left_ff; fr = right_ff;
      if (in_point.valid && near) begin
         if (in_left && -mag < left_ff) fl = -mag;
         if (in_right && mag > right_ff) fr = mag;
      end
      left_in = left_ff; right_in = right_ff;
      if (in_go) begin
         left_in = fl; right_in = fr;
         if (in_point.last) begin
            left_in = '0; right_in = '0;
         end
      end
   end

   assign push = in_go && in_point.last;

   // result queue
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0; right_ff <= '0; wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         left_ff <= left_in; right_ff <= right_in;
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop && !empty) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (push ? 1'b1 : 1'b0) - ((pop && !empty) ? 1'b1 : 1'b0);
      end
      if (push) begin
         q_turn[wp_ff] <= fl + fr;
         q_spd[wp_ff] <= fwd_speed;
      end
   end

   assign empty = (cnt_ff == '0);
   assign room = (cnt_ff < (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 1));
   assign turn_rate = signed'(q_turn[rp_ff]);
   assign linear_speed = q_spd[rp_ff];

`ifndef NO_ASSERTIONS
   a_left_sign: assert property (@(posedge clock) disable iff (reset)
      left_ff <= 17'sd0) else $error("left correction positive");
   a_right_sign: assert property (@(posedge clock) disable iff (reset)
      right_ff >= 17'sd0) else $error("right correction negative");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> cnt_ff < (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH)) else $error("queue overflow");
`endif
endmodule
